// ----- rtl/lrars_pkg.sv -----
package lrars_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int TREE_NODES   = 4096;

  localparam int DATA_W  = 32;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 10;
  localparam int CMD_W   = 2;
  localparam int NODE_W  = $clog2(TREE_NODES);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W    = $clog2(STACK_DEPTH);

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUM  = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [IDX_W-1:0]  s;
    logic [IDX_W-1:0]  e;
    logic              right;
  } frame_t;

endpackage

// ----- rtl/lrars_if.sv -----
interface lrars_in_if import lrars_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         first_index;
  logic [IDX_W-1:0]         last_index;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, cmd, first_index, last_index, operand, input ready);
  modport sink   (input valid, cmd, first_index, last_index, operand, output ready);
endinterface

interface lrars_out_if import lrars_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface

interface lrars_cfg_if import lrars_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] elements_in_use;

  modport source (output valid, elements_in_use, input ready);
  modport sink   (input valid, elements_in_use, output ready);
endinterface

// ----- rtl/lazy_range_add_range_sum_tree.sv -----
// Lazy segment tree, range add / range sum, node sums and pending adds in two RAMs.
// Each visited node steps through read, push-down, child pending updates and write back,
// and each pull-up reads both child sums and writes their total back to the parent node.
// A load descends to its leaf and writes the operand there; the final load also rebuilds the tree.
// One transaction at a time; a finished sum waits in the output register.
// After reset and after each elements_in_use write a clearing pass over every node of both RAMs runs first.
module lazy_range_add_range_sum_tree import lrars_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrars_cfg_if.sink   cfg_i,
  lrars_in_if.sink    in_i,
  lrars_out_if.source out_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LEAF  = 4'd2;
  localparam logic [3:0] S_CALL  = 4'd3;
  localparam logic [3:0] S_V1    = 4'd4;
  localparam logic [3:0] S_V2    = 4'd5;
  localparam logic [3:0] S_V3    = 4'd6;
  localparam logic [3:0] S_RET   = 4'd7;
  localparam logic [3:0] S_P0    = 4'd8;
  localparam logic [3:0] S_P1    = 4'd9;
  localparam logic [3:0] S_P2    = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SUM   = 2'd1;
  localparam logic [1:0] OP_BUILD = 2'd2;

  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(TREE_NODES - 1);
  localparam logic [CNT_W-1:0]  N_MAX     = CNT_W'(MAX_ELEMENTS);

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  elems_q, elems_d;
  logic [CNT_W-1:0]  load_cnt_q, load_cnt_d;
  logic [1:0]        op_q, op_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic              out_valid_q, out_valid_d;

  logic [IDX_W-1:0]  first_q, first_d, last_q, last_d;
  logic [DATA_W-1:0] operand_q, operand_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [IDX_W-1:0]  s_q, s_d, e_q, e_d;
  logic [DATA_W-1:0] delta_q, delta_d, sumv_q, sumv_d, prod_q, prod_d;
  logic [DATA_W-1:0] acc_q, acc_d, tmp_q, tmp_d, out_sum_q, out_sum_d;
  frame_t            stack_q [STACK_DEPTH];
  frame_t            stack_d [STACK_DEPTH];

  logic              sum_we, pend_we;
  logic [NODE_W-1:0] sum_waddr, sum_raddr, pend_waddr, pend_raddr;
  logic [DATA_W-1:0] sum_wdata, pend_wdata, sum_rdata, pend_rdata;

  logic [CNT_W-1:0]  span;
  logic [IDX_W-1:0]  span_last, mid, top_mid;
  logic [CNT_W-1:0]  len;
  logic [NODE_W-1:0] lchild, rchild, top_l, top_r;
  logic              covered, disjoint, leaf;
  logic [SP_W-1:0]   sp_m1;
  frame_t            top;
  frame_t            push_frame;

  lrars_ram #(.Width(DATA_W), .Depth(TREE_NODES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  lrars_ram #(.Width(DATA_W), .Depth(TREE_NODES)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  assign span = (elems_q == '0) ? CNT_W'(1) : ((elems_q > N_MAX) ? N_MAX : elems_q);
  assign span_last = IDX_W'(span - CNT_W'(1));

  // node numbers stay below 4 * MAX_ELEMENTS, so children fit NODE_W
  assign lchild = {node_q[NODE_W-2:0], 1'b1};
  assign rchild = lchild + NODE_W'(1);
  assign mid = IDX_W'(({1'b0, s_q} + {1'b0, e_q}) >> 1);
  assign len = ({1'b0, e_q} - {1'b0, s_q}) + CNT_W'(1);
  assign leaf = (s_q == e_q);
  assign covered = (s_q >= first_q) && (e_q <= last_q);
  assign disjoint = (s_q > last_q) || (e_q < first_q);

  assign sp_m1 = sp_q - SP_W'(1);
  assign top = stack_q[sp_m1];
  assign top_l = {top.node[NODE_W-2:0], 1'b1};
  assign top_r = top_l + NODE_W'(1);
  assign top_mid = IDX_W'(({1'b0, top.s} + {1'b0, top.e}) >> 1);

  assign push_frame = '{node: node_q, s: s_q, e: e_q, right: 1'b0};

  assign cfg_i.ready = 1'b1;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.range_sum = out_sum_q;

  always_comb begin
    state_d = state_q;
    elems_d = elems_q;
    load_cnt_d = load_cnt_q;
    op_d = op_q;
    sp_d = sp_q;
    clr_d = clr_q;
    first_d = first_q;
    last_d = last_q;
    operand_d = operand_q;
    node_d = node_q;
    s_d = s_q;
    e_d = e_q;
    delta_d = delta_q;
    sumv_d = sumv_q;
    prod_d = prod_q;
    acc_d = acc_q;
    tmp_d = tmp_q;
    out_sum_d = out_sum_q;
    out_valid_d = out_valid_q && !out_o.ready;
    stack_d = stack_q;
    sum_we = 1'b0;
    sum_waddr = node_q;
    sum_wdata = '0;
    sum_raddr = node_q;
    pend_we = 1'b0;
    pend_waddr = node_q;
    pend_wdata = '0;
    pend_raddr = node_q;

    case (state_q)
      S_CLEAR: begin
        sum_we = 1'b1;
        pend_we = 1'b1;
        sum_waddr = clr_q;
        pend_waddr = clr_q;
        clr_d = clr_q + NODE_W'(1);
        if (clr_q == NODE_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          first_d = in_i.first_index;
          last_d = in_i.last_index;
          operand_d = in_i.operand;
          node_d = '0;
          s_d = '0;
          e_d = span_last;
          sp_d = '0;
          acc_d = '0;
          case (in_i.cmd)
            CMD_LOAD: begin
              if (load_cnt_q < span) begin
                state_d = S_LEAF;
              end
            end
            CMD_ADD: begin
              op_d = OP_ADD;
              state_d = S_CALL;
            end
            CMD_SUM: begin
              op_d = OP_SUM;
              state_d = S_CALL;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LEAF: begin
        if (leaf) begin
          sum_we = 1'b1;
          sum_wdata = operand_q;
          load_cnt_d = load_cnt_q + CNT_W'(1);
          if (load_cnt_d == span) begin
            op_d = OP_BUILD;
            node_d = '0;
            s_d = '0;
            e_d = span_last;
            sp_d = '0;
            state_d = S_CALL;
          end else begin
            state_d = S_IDLE;
          end
        end else if (load_cnt_q[IDX_W-1:0] <= mid) begin
          node_d = lchild;
          e_d = mid;
        end else begin
          node_d = rchild;
          s_d = mid + IDX_W'(1);
        end
      end
      S_CALL: begin
        if (op_q == OP_BUILD) begin
          pend_we = 1'b1;
          if (leaf) begin
            state_d = S_RET;
          end else begin
            stack_d[sp_q] = push_frame;
            sp_d = sp_q + SP_W'(1);
            node_d = lchild;
            e_d = mid;
          end
        end else if (disjoint) begin
          state_d = S_RET;
        end else begin
          state_d = S_V1;
        end
      end
      S_V1: begin
        delta_d = pend_rdata + (((op_q == OP_ADD) && covered) ? operand_q : '0);
        sumv_d = sum_rdata;
        pend_we = 1'b1;
        pend_raddr = lchild;
        state_d = S_V2;
      end
      S_V2: begin
        prod_d = delta_q * DATA_W'(len);
        pend_we = !leaf;
        pend_waddr = lchild;
        pend_wdata = pend_rdata + delta_q;
        pend_raddr = rchild;
        state_d = S_V3;
      end
      S_V3: begin
        pend_we = !leaf;
        pend_waddr = rchild;
        pend_wdata = pend_rdata + delta_q;
        sum_we = 1'b1;
        sum_wdata = sumv_q + prod_q;
        if (covered) begin
          acc_d = acc_q + sumv_q + prod_q;
          state_d = S_RET;
        end else begin
          stack_d[sp_q] = push_frame;
          sp_d = sp_q + SP_W'(1);
          node_d = lchild;
          e_d = mid;
          state_d = S_CALL;
        end
      end
      S_RET: begin
        if (sp_q == '0) begin
          state_d = (op_q == OP_SUM) ? S_DONE : S_IDLE;
        end else if (!top.right) begin
          stack_d[sp_m1].right = 1'b1;
          node_d = top_r;
          s_d = top_mid + IDX_W'(1);
          e_d = top.e;
          state_d = S_CALL;
        end else if (op_q == OP_SUM) begin
          sp_d = sp_m1;
        end else begin
          state_d = S_P0;
        end
      end
      S_P0: begin
        sum_raddr = top_l;
        state_d = S_P1;
      end
      S_P1: begin
        tmp_d = sum_rdata;
        sum_raddr = top_r;
        state_d = S_P2;
      end
      S_P2: begin
        sum_we = 1'b1;
        sum_waddr = top.node;
        sum_wdata = tmp_q + sum_rdata;
        sp_d = sp_m1;
        state_d = S_RET;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_sum_d = acc_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_i.valid) begin
      elems_d = cfg_i.elements_in_use;
      load_cnt_d = '0;
      clr_d = '0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      elems_q <= N_MAX;
      load_cnt_q <= '0;
      op_q <= OP_ADD;
      sp_q <= '0;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      elems_q <= elems_d;
      load_cnt_q <= load_cnt_d;
      op_q <= op_d;
      sp_q <= sp_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q <= last_d;
    operand_q <= operand_d;
    node_q <= node_d;
    s_q <= s_d;
    e_q <= e_d;
    delta_q <= delta_d;
    sumv_q <= sumv_d;
    prod_q <= prod_d;
    acc_q <= acc_d;
    tmp_q <= tmp_d;
    out_sum_q <= out_sum_d;
    stack_q <= stack_d;
  end

endmodule

// ----- rtl/lrars_ram.sv -----
module lrars_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
